@@ hdl/lc_pkg.sv @@
// Shared types, constants and the keyword ROM of the lexeme classifier.
package lc_pkg;

    localparam int MAX_LEXEME = 8;
    localparam int ROM_SLOTS  = 64;
    localparam int ROM_AW     = 6;
    localparam int CNT_W      = 7;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [1:0] CLASS_TERMINAL   = 2'd0;
    localparam logic [1:0] CLASS_LITERAL    = 2'd1;
    localparam logic [1:0] CLASS_IDENTIFIER = 2'd2;
    localparam logic [1:0] CLASS_INVALID    = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_FULL     = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  len;
        logic        overflow;
        logic [15:0] line;
        logic        last;
    } job_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    // Reorder a right-justified string literal so the first character sits in bits 7:0.
    function automatic logic [63:0] pack_text(input logic [63:0] s);
        logic [63:0] v;
        logic [3:0]  k;
        v = '0;
        k = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (s[8*j +: 8] != 8'd0)
            begin
                v[8*k[2:0] +: 8] = s[8*j +: 8];
                k = k + 4'd1;
            end
        end
        return v;
    endfunction

    function automatic logic [63:0] rom_entry(input logic [ROM_AW-1:0] idx);
        logic [63:0] s;
        case (idx)
            6'd0:  s = "auto";
            6'd1:  s = "double";
            6'd2:  s = "int";
            6'd3:  s = "struct";
            6'd4:  s = "break";
            6'd5:  s = "else";
            6'd6:  s = "long";
            6'd7:  s = "switch";
            6'd8:  s = "case";
            6'd9:  s = "enum";
            6'd10: s = "register";
            6'd11: s = "typedef";
            6'd12: s = "char";
            6'd13: s = "extern";
            6'd14: s = "return";
            6'd15: s = "union";
            6'd16: s = "const";
            6'd17: s = "float";
            6'd18: s = "short";
            6'd19: s = "unsigned";
            6'd20: s = "continue";
            6'd21: s = "for";
            6'd22: s = "signed";
            6'd23: s = "void";
            6'd24: s = "default";
            6'd25: s = "goto";
            6'd26: s = "sizeof";
            6'd27: s = "volatile";
            6'd28: s = "do";
            6'd29: s = "if";
            6'd30: s = "static";
            6'd31: s = "while";
            6'd32: s = "!";
            6'd33: s = "*";
            6'd34: s = "+";
            6'd35: s = "<";
            6'd36: s = "#";
            6'd37: s = "(";
            6'd38: s = "=";
            6'd39: s = "|";
            6'd40: s = ">";
            6'd41: s = "%";
            6'd42: s = ")";
            6'd43: s = "~";
            6'd44: s = ";";
            6'd45: s = "/";
            6'd46: s = "^";
            6'd47: s = "-";
            6'd48: s = "[";
            6'd49: s = ":";
            6'd50: s = ",";
            6'd51: s = "?";
            6'd52: s = "&";
            6'd53: s = "-";
            6'd54: s = "]";
            6'd55: s = "{";
            6'd56: s = "}";
            default: s = '0;
        endcase
        return pack_text(s);
    endfunction

endpackage

@@ hdl/lc_front.sv @@
// Character intake: gathers lexemes and issues classify jobs.
module lc_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   char_code,
    output logic         push,
    output lc_pkg::job_t push_job,
    input  logic         q_full
);
    import lc_pkg::*;

    logic [63:0] buf_reg;
    logic [3:0]  len_reg;
    logic        ovf_reg;
    logic [15:0] line_reg;
    logic        b_pend_reg;
    logic [7:0]  b_char_reg;
    logic [15:0] b_line_reg;

    logic accept, alnum, pending, is_other;
    job_t job_a, job_b;

    assign in_stall = b_pend_reg | q_full;
    assign accept   = in_valid & ~in_stall;
    assign alnum    = is_letter(char_code) | is_digit(char_code);
    assign pending  = (len_reg != 4'd0) | ovf_reg;
    assign is_other = (char_code != CHAR_NEWLINE) && (char_code != CHAR_SPACE);

    always_comb
    begin
        job_a.key      = buf_reg;
        job_a.len      = len_reg;
        job_a.overflow = ovf_reg;
        job_a.line     = line_reg;
        job_a.last     = ~is_other;
        job_b.key      = {56'd0, b_pend_reg ? b_char_reg : char_code};
        job_b.len      = 4'd1;
        job_b.overflow = 1'b0;
        job_b.line     = b_pend_reg ? b_line_reg : line_reg;
        job_b.last     = 1'b1;
        push     = 1'b0;
        push_job = job_a;
        if (b_pend_reg && !q_full)
        begin
            push     = 1'b1;
            push_job = job_b;
        end
        else if (accept && !alnum)
        begin
            if (pending)
            begin
                push     = 1'b1;
                push_job = job_a;
            end
            else if (is_other)
            begin
                push     = 1'b1;
                push_job = job_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg    <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            line_reg   <= 16'd1;
            b_pend_reg <= 1'b0;
            b_char_reg <= '0;
            b_line_reg <= '0;
        end
        else
        begin
            if (b_pend_reg && !q_full)
                b_pend_reg <= 1'b0;
            if (accept)
            begin
                if (alnum)
                begin
                    if (len_reg < 4'(MAX_LEXEME))
                    begin
                        buf_reg[8*len_reg[2:0] +: 8] <= char_code;
                        len_reg <= len_reg + 4'd1;
                    end
                    else
                        ovf_reg <= 1'b1;
                end
                else
                begin
                    buf_reg <= '0;
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                    // hold the one-character job until the lexeme job has gone in
                    if (pending && is_other)
                    begin
                        b_pend_reg <= 1'b1;
                        b_char_reg <= char_code;
                        b_line_reg <= line_reg;
                    end
                    if (char_code == CHAR_NEWLINE && line_reg != 16'hFFFF)
                        line_reg <= line_reg + 16'd1;
                end
            end
        end
    end

endmodule

@@ hdl/lc_queue.sv @@
// Four-entry job queue between intake and classifier.
module lc_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lc_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output lc_pkg::job_t head
);
    import lc_pkg::*;

    job_t       mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign head      = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 2'd1;
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 3'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 3'd1;
        end
    end

endmodule

@@ hdl/lc_back.sv @@
// Classifier: ROM scan, class table search and insert, result register.
module lc_back
#(
    parameter int TERMINAL_DEPTH   = 32,
    parameter int LITERAL_DEPTH    = 32,
    parameter int IDENTIFIER_DEPTH = 32,
    parameter int KEYWORD_COUNT    = 57
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  lc_pkg::job_t job,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   token_class,
    output logic [4:0]   table_index,
    output logic         is_new,
    output logic [1:0]   error_code,
    output logic [15:0]  line_number,
    output logic         last_of_run
);
    import lc_pkg::*;

    localparam int T_AW = (TERMINAL_DEPTH > 1) ? $clog2(TERMINAL_DEPTH) : 1;
    localparam int L_AW = (LITERAL_DEPTH > 1) ? $clog2(LITERAL_DEPTH) : 1;
    localparam int I_AW = (IDENTIFIER_DEPTH > 1) ? $clog2(IDENTIFIER_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_ROM, S_TAB, S_CMP, S_OUT} state_t;

    state_t            state_reg;
    job_t              job_reg;
    logic              digits_reg, ident_reg;
    logic [1:0]        class_reg, err_reg;
    logic [CNT_W-1:0]  idx_reg, scan_reg;
    logic              new_reg;
    logic [ROM_AW-1:0] rom_reg;
    logic [63:0]       rd_reg;
    logic [CNT_W-1:0]  tcnt_reg, lcnt_reg, icnt_reg;

    logic [63:0] t_mem [TERMINAL_DEPTH];
    logic [63:0] l_mem [LITERAL_DEPTH];
    logic [63:0] i_mem [IDENTIFIER_DEPTH];

    logic             all_digits, ident;
    logic [CNT_W-1:0] n_sel, depth_sel;
    logic [63:0]      rom_val;
    logic             do_write, do_read;

    always_comb
    begin
        all_digits = 1'b1;
        ident      = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < job.len)
            begin
                if (!is_digit(job.key[8*i +: 8]))
                    all_digits = 1'b0;
                if (!is_letter(job.key[8*i +: 8]))
                    ident = 1'b0;
            end
        end
        if (job.len == 4'd0)
        begin
            all_digits = 1'b0;
            ident      = 1'b0;
        end
    end

    always_comb
    begin
        case (class_reg)
            CLASS_TERMINAL:
            begin
                n_sel     = tcnt_reg;
                depth_sel = CNT_W'(TERMINAL_DEPTH);
            end
            CLASS_LITERAL:
            begin
                n_sel     = lcnt_reg;
                depth_sel = CNT_W'(LITERAL_DEPTH);
            end
            default:
            begin
                n_sel     = icnt_reg;
                depth_sel = CNT_W'(IDENTIFIER_DEPTH);
            end
        endcase
    end

    assign rom_val   = rom_entry(rom_reg);
    assign pop       = (state_reg == S_IDLE) && job_valid;
    assign do_read   = (state_reg == S_TAB) && (scan_reg != n_sel);
    assign do_write  = (state_reg == S_TAB) && (scan_reg == n_sel) && (n_sel < depth_sel);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            case (class_reg)
                CLASS_TERMINAL: t_mem[scan_reg[T_AW-1:0]] <= job_reg.key;
                CLASS_LITERAL:  l_mem[scan_reg[L_AW-1:0]] <= job_reg.key;
                default:        i_mem[scan_reg[I_AW-1:0]] <= job_reg.key;
            endcase
        end
        if (do_read)
        begin
            case (class_reg)
                CLASS_TERMINAL: rd_reg <= t_mem[scan_reg[T_AW-1:0]];
                CLASS_LITERAL:  rd_reg <= l_mem[scan_reg[L_AW-1:0]];
                default:        rd_reg <= i_mem[scan_reg[I_AW-1:0]];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            job_reg    <= '0;
            digits_reg <= 1'b0;
            ident_reg  <= 1'b0;
            class_reg  <= CLASS_TERMINAL;
            err_reg    <= ERR_NONE;
            idx_reg    <= '0;
            scan_reg   <= '0;
            new_reg    <= 1'b0;
            rom_reg    <= '0;
            tcnt_reg   <= '0;
            lcnt_reg   <= '0;
            icnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg    <= job;
                        digits_reg <= all_digits;
                        ident_reg  <= ident;
                        idx_reg    <= '0;
                        new_reg    <= 1'b0;
                        scan_reg   <= '0;
                        rom_reg    <= '0;
                        if (job.overflow)
                        begin
                            class_reg <= CLASS_INVALID;
                            err_reg   <= ERR_TOO_LONG;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            err_reg   <= ERR_NONE;
                            state_reg <= S_ROM;
                        end
                    end
                end
                S_ROM:
                begin
                    if (rom_val != 64'd0 && rom_val == job_reg.key)
                    begin
                        class_reg <= CLASS_TERMINAL;
                        state_reg <= S_TAB;
                    end
                    else if (rom_reg == ROM_AW'(KEYWORD_COUNT - 1))
                    begin
                        if (digits_reg)
                        begin
                            class_reg <= CLASS_LITERAL;
                            state_reg <= S_TAB;
                        end
                        else if (ident_reg)
                        begin
                            class_reg <= CLASS_IDENTIFIER;
                            state_reg <= S_TAB;
                        end
                        else
                        begin
                            class_reg <= CLASS_INVALID;
                            err_reg   <= ERR_INVALID;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        rom_reg <= rom_reg + ROM_AW'(1);
                end
                S_TAB:
                begin
                    if (scan_reg == n_sel)
                    begin
                        if (n_sel < depth_sel)
                        begin
                            idx_reg <= n_sel;
                            new_reg <= 1'b1;
                            case (class_reg)
                                CLASS_TERMINAL: tcnt_reg <= tcnt_reg + CNT_W'(1);
                                CLASS_LITERAL:  lcnt_reg <= lcnt_reg + CNT_W'(1);
                                default:        icnt_reg <= icnt_reg + CNT_W'(1);
                            endcase
                        end
                        else
                            err_reg <= ERR_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_reg == job_reg.key)
                    begin
                        idx_reg   <= scan_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + CNT_W'(1);
                        state_reg <= S_TAB;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = state_reg == S_OUT;
    assign token_class = class_reg;
    assign table_index = idx_reg[4:0];
    assign is_new      = new_reg;
    assign error_code  = err_reg;
    assign line_number = job_reg.line;
    assign last_of_run = job_reg.last;

endmodule

@@ hdl/c_lexeme_classifier.sv @@
// Top level of the character-serial lexeme classifier.
// Input channel: one source byte on char_code per transfer (in_valid / in_stall).
// Output channel: one token result per transfer (out_valid / out_stall) with
// token_class, table_index, is_new, error_code, line_number and last_of_run.
// Letters and digits only extend the pending lexeme and give no result; a
// separator or other byte ends it and queues up to two classify jobs.
// Intake takes a byte per cycle unless in_stall is high; a byte that queues two
// jobs holds intake until its second job is queued. A four-entry queue lets
// intake run ahead of the classifier. Classifying a job scans the keyword ROM
// one entry per cycle until a match or the last entry, then searches its class
// table entry by entry, inserts on a miss if not full and registers the result.
// An overlong lexeme skips the scans. The classifier loop sets the sustained rate.
// Reset empties the queue, clears the lexeme and table counts and sets the
// line number to one; table contents need no clearing.
// A stalled result holds in its register; the queue fills and then in_stall rises.
module c_lexeme_classifier
#(
    parameter int TERMINAL_DEPTH   = 32,
    parameter int LITERAL_DEPTH    = 32,
    parameter int IDENTIFIER_DEPTH = 32,
    parameter int KEYWORD_COUNT    = 57
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  token_class,
    output logic [4:0]  table_index,
    output logic        is_new,
    output logic [1:0]  error_code,
    output logic [15:0] line_number,
    output logic        last_of_run
);
    import lc_pkg::*;

    logic push, q_full, pop, q_valid;
    job_t push_job, head;

    lc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .char_code(char_code),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    lc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .not_empty(q_valid),
        .head     (head)
    );

    lc_back
    #(
        .TERMINAL_DEPTH  (TERMINAL_DEPTH),
        .LITERAL_DEPTH   (LITERAL_DEPTH),
        .IDENTIFIER_DEPTH(IDENTIFIER_DEPTH),
        .KEYWORD_COUNT   (KEYWORD_COUNT)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job        (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_class(token_class),
        .table_index(table_index),
        .is_new     (is_new),
        .error_code (error_code),
        .line_number(line_number),
        .last_of_run(last_of_run)
    );

endmodule
